>>> design/nsr_pkg.sv
// Shared types and constants for the Newton square root block.
package nsr_pkg;

  localparam int unsigned RAD_W         = 33;
  localparam int unsigned ROOT_W        = 32;
  localparam int unsigned ITER_W        = 6;
  localparam int unsigned TOL_W         = 17;
  localparam int unsigned MAX_ITER_DEF  = 32;
  localparam int unsigned FRAC_BITS_DEF = 16;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;

  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(66);
  localparam logic [ITER_W-1:0] ITER_SAT  = '1;

  // register index, taken from paddr[2]
  localparam logic REG_TOLERANCE = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_UPDATE,
    ST_REPORT
  } nsr_state_t;

  typedef struct packed {
    logic load;
    logic div_start;
    logic update;
  } nsr_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic converged;
    logic last_step;
  } nsr_stat_t;

endpackage

>>> design/nsr_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module nsr_div #(
  parameter int unsigned W = 49
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         div_start,
  input  logic [W-1:0] dividend,
  input  logic [W-1:0] divisor,
  output logic         div_busy,
  output logic [W-1:0] quotient
);
  import nsr_pkg::*;

  localparam int unsigned CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy_r, busy_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [W-1:0]     rem_r, rem_nxt;
  logic [W-1:0]     quo_r, quo_nxt;
  logic [W-1:0]     dsor_r, dsor_nxt;
  logic [W:0]       rem_sh;
  logic [W:0]       diff;
  logic             qbit;

  always_comb begin
    rem_sh   = {rem_r, quo_r[W-1]};
    diff     = rem_sh - {1'b0, dsor_r};
    qbit     = (rem_sh >= {1'b0, dsor_r});
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsor_nxt = dsor_r;
    if (div_start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(W - 1);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsor_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = qbit ? diff[W-1:0] : rem_sh[W-1:0];
      quo_nxt = {quo_r[W-2:0], qbit};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    dsor_r <= dsor_nxt;
  end

  assign div_busy = busy_r;
  assign quotient = quo_r;

endmodule

>>> design/nsr_dp.sv
// Datapath: operand, estimate, step count, divider and result registers.
module nsr_dp #(
  parameter int unsigned MAX_ITER  = 32,
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                         clk,
  input  nsr_pkg::nsr_cmd_t            cmd,
  output nsr_pkg::nsr_stat_t           stat,
  input  logic [nsr_pkg::RAD_W-1:0]    in_radicand,
  input  logic [nsr_pkg::TOL_W-1:0]    tolerance,
  output logic [nsr_pkg::ROOT_W-1:0]   out_root,
  output logic [nsr_pkg::ITER_W-1:0]   out_iterations,
  output logic                         out_limit_hit
);
  import nsr_pkg::*;

  localparam int unsigned DIVD_W = RAD_W + FRAC_BITS;
  localparam int unsigned STEP_W = $clog2(MAX_ITER + 1);
  localparam int unsigned CMP_W  = (STEP_W > ITER_W) ? STEP_W : ITER_W;

  logic [RAD_W-1:0]  x_r;
  logic [DIVD_W-1:0] prev_r;
  logic [STEP_W-1:0] steps_r;
  logic [ROOT_W-1:0] root_r;
  logic [ITER_W-1:0] iter_r;
  logic              limit_r;

  logic [DIVD_W-1:0] dividend;
  logic [DIVD_W-1:0] quo;
  logic [DIVD_W-1:0] q_eff;
  logic [DIVD_W:0]   sum;
  logic [DIVD_W-1:0] y;
  logic [DIVD_W-1:0] delta;
  logic [STEP_W-1:0] steps_inc;
  logic [CMP_W-1:0]  steps_cmp;
  logic              converged;
  logic              div_busy;

  assign dividend = {x_r, {FRAC_BITS{1'b0}}};

  nsr_div #(
    .W(DIVD_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (1'b1),
    .div_start(cmd.div_start),
    .dividend (dividend),
    .divisor  (prev_r),
    .div_busy (div_busy),
    .quotient (quo)
  );

  always_comb begin
    // a zero estimate gives a zero quotient
    q_eff     = (prev_r == '0) ? '0 : quo;
    sum       = {1'b0, prev_r} + {1'b0, q_eff};
    y         = sum[DIVD_W:1];
    delta     = (y >= prev_r) ? (y - prev_r) : (prev_r - y);
    converged = (delta <= DIVD_W'(tolerance));
    steps_inc = steps_r + 1'b1;
    steps_cmp = CMP_W'(steps_inc);
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r     <= in_radicand;
      prev_r  <= DIVD_W'(1) << FRAC_BITS;
      steps_r <= '0;
    end else if (cmd.update) begin
      steps_r <= steps_inc;
      if (!converged) begin
        prev_r <= y;
      end
      root_r  <= (y[DIVD_W-1:ROOT_W] != '0) ? '1 : y[ROOT_W-1:0];
      iter_r  <= (steps_cmp > CMP_W'(ITER_SAT)) ? ITER_SAT : ITER_W'(steps_inc);
      limit_r <= !converged;
    end
  end

  assign stat.div_busy  = div_busy;
  assign stat.converged = converged;
  assign stat.last_step = (steps_inc == STEP_W'(MAX_ITER));

  assign out_root       = root_r;
  assign out_iterations = iter_r;
  assign out_limit_hit  = limit_r;

endmodule

>>> design/nsr_ctrl.sv
// Controller: sequences load, divide, update and report for one operand.
module nsr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  output logic                out_valid,
  output nsr_pkg::nsr_cmd_t   cmd,
  input  nsr_pkg::nsr_stat_t  stat
);
  import nsr_pkg::*;

  nsr_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DIV_START;
        end
      end
      ST_DIV_START: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (!stat.div_busy) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        if (stat.converged || stat.last_step) begin
          state_nxt = ST_REPORT;
        end else begin
          state_nxt = ST_DIV_START;
        end
      end
      ST_REPORT: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule

>>> design/newton_square_root.sv
// Newton-Raphson square root, unsigned fixed point (Q(33-FRAC_BITS).FRAC_BITS).
//
// Input: drive in_radicand and pulse start; the operand is taken at a rising
// edge where start is high and busy is low. busy stays high until the result
// has been shown.
// Output: out_valid is high for exactly one cycle with out_root,
// out_iterations and out_limit_hit; the receiver must take it then.
// Each Newton step issues a divide to the bit-serial divider (RAD_W + FRAC_BITS
// bits wide, 49 at the default width), waits for it to go idle and then updates
// the estimate; the next operand is taken the cycle after the result.
// Iterations stop at convergence or after MAX_ITER steps (limit flag set).
// Config: APB write at addresses 0 to 3 sets the 17-bit tolerance; others
// (4 to 7) are ignored and read as zero. Write only while busy is low.
// Reset (synchronous, active low) returns to idle and sets tolerance to 66.
module newton_square_root #(
  parameter int unsigned MAX_ITER  = nsr_pkg::MAX_ITER_DEF,
  parameter int unsigned FRAC_BITS = nsr_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [nsr_pkg::RAD_W-1:0]       in_radicand,
  output logic                            out_valid,
  output logic [nsr_pkg::ROOT_W-1:0]      out_root,
  output logic [nsr_pkg::ITER_W-1:0]      out_iterations,
  output logic                            out_limit_hit,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [nsr_pkg::APB_ADDR_W-1:0]  paddr,
  input  logic [nsr_pkg::APB_DATA_W-1:0]  pwdata,
  output logic [nsr_pkg::APB_DATA_W-1:0]  prdata,
  output logic                            pready
);
  import nsr_pkg::*;

  logic [TOL_W-1:0] tol_r;
  logic             reg_sel;
  nsr_cmd_t         cmd;
  nsr_stat_t        stat;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[2] == REG_TOLERANCE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      tol_r <= pwdata[TOL_W-1:0];
    end
  end

  assign prdata = reg_sel ? APB_DATA_W'(tol_r) : '0;

  nsr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .out_valid(out_valid),
    .cmd      (cmd),
    .stat     (stat)
  );

  nsr_dp #(
    .MAX_ITER (MAX_ITER),
    .FRAC_BITS(FRAC_BITS)
  ) u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .in_radicand   (in_radicand),
    .tolerance     (tol_r),
    .out_root      (out_root),
    .out_iterations(out_iterations),
    .out_limit_hit (out_limit_hit)
  );

endmodule
